FILE: sv/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the box transform block.
// ----------------------------------------------------------------------------
package aabb_pkg;

   localparam int unsigned NUM_REGS = 8;
   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      ROW0_LO, ROW0_HI, ROW1_LO, ROW1_HI, ROW2_LO, ROW2_HI, ROW3_LO, ROW3_HI
   } matrix_reg_type;

   typedef struct packed {
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_min_x;
      logic signed [31:0] out_min_y;
      logic signed [31:0] out_min_z;
      logic signed [31:0] out_max_x;
      logic signed [31:0] out_max_y;
      logic signed [31:0] out_max_z;
      logic               projected;
      logic               saturated;
   } rsp_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                               output logic s);
      logic signed [65:0] mx;
      logic signed [65:0] mn;
      mx = 66'sh0_7FFF_FFFF;
      mn = -66'sh0_8000_0000;
      s = 1'b0;
      if (v > mx) begin
         s = 1'b1;
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < mn) begin
         s = 1'b1;
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

FILE: sv/aabb_matrix_transform.sv
// ----------------------------------------------------------------------------
// aabb_matrix_transform
// Transforms an axis-aligned box by a 4x4 fixed-point matrix over its corners.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// req     | in  | req_valid/req_stall| req_type box
// rsp     | out | rsp_valid/rsp_stall| rsp_type box, projected, saturated
// csr     | in  | csr_valid/csr_ready| csr_index, csr_data
//
// Each request occupies the corner sequencer for its eight corners: one corner per
// cycle, while the pipeline is not frozen, through a shared 16-multiplier
// matrix-vector pipeline, and no new box is taken until the current box's last
// corner has entered. Path to rsp_valid: the 7 remaining corners, 3 matrix
// stages, 33 + FRAC_BITS divider stages and the output register.
// Reset (synchronous) loads the identity matrix and empties the pipeline.
// rsp_stall while rsp_valid is high freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module aabb_matrix_transform
   import aabb_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
   localparam int DIVLAT = 32 + FRAC_BITS + 1;

   logic [63:0] mat_ff [NUM_REGS];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            case (CSR_IDX_W'(i)) inside
               ROW0_LO, ROW2_HI: mat_ff[i] <= 64'(ONE);
               ROW1_LO, ROW3_HI: mat_ff[i] <= {ONE, 32'd0};
               default:          mat_ff[i] <= '0;
            endcase
         end
      end else if (csr_valid && csr_ready) begin
         mat_ff[csr_index] <= csr_data;
      end
   end

   function automatic logic signed [31:0] elem(input int r, input int c,
                                                input logic [63:0] m [NUM_REGS]);
      logic [63:0] w;
      w = m[{r[1:0], c[1]}];
      elem = c[0] ? w[63:32] : w[31:0];
   endfunction

   // whole pipeline advances together
   logic en;
   assign en = !(rsp_valid && rsp_stall);

   // ---------------- corner sequencer ----------------
   logic        busy_ff;
   logic [2:0]  cnt_ff;
   req_type     box_ff;
   assign req_stall = busy_ff || !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (en) begin
         if (!busy_ff && req_valid) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) busy_ff <= 1'b0;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en && !busy_ff && req_valid) box_ff <= req_data;
   end

   logic        c_vld;
   logic [2:0]  c_idx;
   req_type     c_box;
   assign c_vld = busy_ff || (req_valid && en);
   assign c_idx = busy_ff ? cnt_ff : 3'd0;
   assign c_box = busy_ff ? box_ff : req_data;

   // stage 1: corner vector
   logic              s1_vld_ff;
   logic [2:0]        s1_idx_ff;
   logic signed [31:0] s1_v_ff [4];
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (en) s1_vld_ff <= c_vld;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s1_idx_ff  <= c_idx;
         s1_v_ff[0] <= c_idx[2] ? c_box.box_max_x : c_box.box_min_x;
         s1_v_ff[1] <= c_idx[1] ? c_box.box_max_y : c_box.box_min_y;
         s1_v_ff[2] <= c_idx[0] ? c_box.box_max_z : c_box.box_min_z;
         s1_v_ff[3] <= ONE;
      end
   end

   // stage 2: sixteen products, floor shifted
   logic              s2_vld_ff;
   logic [2:0]        s2_idx_ff;
   logic signed [63:0] s2_p_ff [4][4];
   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (en) s2_vld_ff <= s1_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s2_idx_ff <= s1_idx_ff;
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               s2_p_ff[r][c] <= (64'(elem(r, c, mat_ff)) * 64'(s1_v_ff[c]))
                                >>> FRAC_BITS;
      end
   end

   // stage 3: sum and saturate
   logic              s3_vld_ff;
   logic [2:0]        s3_idx_ff;
   logic signed [31:0] s3_pt_ff [4];
   logic              s3_sat_ff;
   logic signed [31:0] s3_pt_in [4];
   logic              s3_sat_in;
   always_comb begin
      logic signed [65:0] acc;
      logic s;
      s3_sat_in = 1'b0;
      for (int r = 0; r < 4; r++) begin
         acc = 66'(s2_p_ff[r][0]) + 66'(s2_p_ff[r][1])
             + 66'(s2_p_ff[r][2]) + 66'(s2_p_ff[r][3]);
         s3_pt_in[r] = sat32(acc, s);
         s3_sat_in = s3_sat_in | s;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (en) s3_vld_ff <= s2_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s3_idx_ff <= s2_idx_ff;
         s3_pt_ff  <= s3_pt_in;
         s3_sat_ff <= s3_sat_in;
      end
   end

   // projection decision follows corner 0 of each box
   logic proj_hold_ff;
   logic proj_now;
   assign proj_now = (s3_idx_ff == 3'd0)
                   ? (s3_pt_ff[3] != ONE && s3_pt_ff[3] > 0) : proj_hold_ff;
   always_ff @(posedge clock) begin
      if (reset) proj_hold_ff <= 1'b0;
      else if (en && s3_vld_ff) proj_hold_ff <= proj_now;
   end

   // divider lanes with matching delay line for control
   logic signed [31:0] d_q [3];
   logic               d_s [3];
   for (genvar a = 0; a < 3; a++) begin : g_div
      aabb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (en),
         .num   (s3_pt_ff[a]),
         .den   (s3_pt_ff[3]),
         .bypass(!proj_now),
         .quo   (d_q[a]),
         .sat   (d_s[a])
      );
   end

   logic       dl_vld_ff  [DIVLAT];
   logic [2:0] dl_idx_ff  [DIVLAT];
   logic       dl_sat_ff  [DIVLAT];
   logic       dl_proj_ff [DIVLAT];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIVLAT; i++) dl_vld_ff[i] <= 1'b0;
      end else if (en) begin
         dl_vld_ff[0] <= s3_vld_ff;
         for (int i = 1; i < DIVLAT; i++) dl_vld_ff[i] <= dl_vld_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         dl_idx_ff[0]  <= s3_idx_ff;
         dl_sat_ff[0]  <= s3_sat_ff;
         dl_proj_ff[0] <= proj_now;
         for (int i = 1; i < DIVLAT; i++) begin
            dl_idx_ff[i]  <= dl_idx_ff[i-1];
            dl_sat_ff[i]  <= dl_sat_ff[i-1];
            dl_proj_ff[i] <= dl_proj_ff[i-1];
         end
      end
   end

   // min/max accumulate over eight corners
   logic signed [31:0] mn_ff [3];
   logic signed [31:0] mx_ff [3];
   logic               acc_sat_ff;
   logic               k_vld;
   logic [2:0]         k_idx;
   logic               k_sat;
   assign k_vld = dl_vld_ff[DIVLAT-1];
   assign k_idx = dl_idx_ff[DIVLAT-1];
   assign k_sat = dl_sat_ff[DIVLAT-1] | d_s[0] | d_s[1] | d_s[2];

   always_ff @(posedge clock) begin
      if (en && k_vld) begin
         for (int a = 0; a < 3; a++) begin
            if (k_idx == 3'd0 || d_q[a] < mn_ff[a]) mn_ff[a] <= d_q[a];
            if (k_idx == 3'd0 || d_q[a] > mx_ff[a]) mx_ff[a] <= d_q[a];
         end
         acc_sat_ff <= (k_idx == 3'd0) ? k_sat : (acc_sat_ff | k_sat);
      end
   end

   // output register
   logic last_ff;
   logic proj_out_ff;
   always_ff @(posedge clock) begin
      if (reset) last_ff <= 1'b0;
      else if (en) last_ff <= k_vld && k_idx == 3'd7;
   end
   always_ff @(posedge clock) begin
      if (en) proj_out_ff <= dl_proj_ff[DIVLAT-1];
   end

   assign rsp_valid = last_ff;
   assign rsp_data.out_min_x = mn_ff[0];
   assign rsp_data.out_min_y = mn_ff[1];
   assign rsp_data.out_min_z = mn_ff[2];
   assign rsp_data.out_max_x = mx_ff[0];
   assign rsp_data.out_max_y = mx_ff[1];
   assign rsp_data.out_max_z = mx_ff[2];
   assign rsp_data.projected = proj_out_ff;
   assign rsp_data.saturated = acc_sat_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> req_stall) else $error("request taken mid-box");
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      (en && s1_vld_ff && s1_idx_ff != 3'd7) |=> (s1_vld_ff &&
      s1_idx_ff == $past(s1_idx_ff) + 3'd1)) else $error("corner order");
   a_out_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(k_vld && k_idx == 3'd7))
      else $error("result without last corner");
`endif
endmodule

FILE: sv/aabb_div.sv
// ----------------------------------------------------------------------------
// aabb_div
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated toward
// zero, saturated to 32 bits; zero divisor saturates by sign of num.
// One quotient bit per stage, stages advance together on enable; bypass passes num through.
// ----------------------------------------------------------------------------
module aabb_div
   import aabb_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   input  logic               bypass,
   output logic signed [31:0] quo,
   output logic               sat
);
   localparam int NW = 32 + FRAC_BITS;   // dividend magnitude width
   localparam int NS = NW;               // one stage per quotient bit

   logic [NW-1:0] rem_ff  [NS+1];
   logic [NW-1:0] q_ff    [NS+1];
   logic [31:0]   d_ff    [NS+1];
   logic          neg_ff  [NS+1];
   logic          zero_ff [NS+1];
   logic signed [31:0] raw_ff [NS+1];
   logic          byp_ff  [NS+1];
   logic [1:0]    nsgn_ff [NS+1];

   logic [31:0] num_mag;
   logic [31:0] den_mag;

   assign num_mag = num[31] ? 32'(-num) : 32'(num);
   assign den_mag = den[31] ? 32'(-den) : 32'(den);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         q_ff[0]    <= {num_mag, {FRAC_BITS{1'b0}}};
         d_ff[0]    <= den_mag;
         neg_ff[0]  <= num[31] ^ den[31];
         zero_ff[0] <= (den == '0);
         raw_ff[0]  <= num;
         byp_ff[0]  <= bypass;
         nsgn_ff[0] <= {num[31], num != '0};
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [NW:0] trial;
      logic [NW:0] shifted;
      assign shifted = {rem_ff[s], q_ff[s][NW-1]};
      assign trial   = shifted - {{(NW-31){1'b0}}, d_ff[s]};
      always_ff @(posedge clock) begin
         if (en) begin
            if (!trial[NW]) begin
               rem_ff[s+1] <= trial[NW-1:0];
               q_ff[s+1]   <= {q_ff[s][NW-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= shifted[NW-1:0];
               q_ff[s+1]   <= {q_ff[s][NW-2:0], 1'b0};
            end
            d_ff[s+1]    <= d_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            zero_ff[s+1] <= zero_ff[s];
            raw_ff[s+1]  <= raw_ff[s];
            byp_ff[s+1]  <= byp_ff[s];
            nsgn_ff[s+1] <= nsgn_ff[s];
         end
      end
   end

   logic signed [65:0] sq;
   logic               qs;
   logic signed [31:0] qv;

   always_comb begin
      sq = neg_ff[NS] ? -$signed({{(66-NW){1'b0}}, q_ff[NS]})
                      : $signed({{(66-NW){1'b0}}, q_ff[NS]});
      qv = sat32(sq, qs);
      if (byp_ff[NS]) begin
         quo = raw_ff[NS];
         sat = 1'b0;
      end else if (zero_ff[NS]) begin
         sat = 1'b1;
         if (nsgn_ff[NS][1])      quo = 32'sh8000_0000;
         else if (nsgn_ff[NS][0]) quo = 32'sh7FFF_FFFF;
         else                     quo = '0;
      end else begin
         quo = qv;
         sat = qs;
      end
   end
endmodule

FILE: tb/tb_aabb_matrix_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_matrix_transform
// Drives random and corner-case boxes through the box transform under a series
// of matrix settings and checks every response against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_aabb_matrix_transform
   import aabb_pkg::*;
;

   localparam int FRAC = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 120;

   // Expected transformed boxes, computed from a local copy of the matrix.
   class box_scoreboard;
      logic [63:0] matrix[NUM_REGS];
      rsp_type     pending_boxes[$];
      int          mismatches;

      function new();
         foreach (matrix[i]) matrix[i] = '0;
         matrix[ROW0_LO] = 64'h1_0000;
         matrix[ROW1_LO] = 64'h1_0000 << 32;
         matrix[ROW2_HI] = 64'h1_0000;
         matrix[ROW3_HI] = 64'h1_0000 << 32;
         mismatches = 0;
      endfunction

      function longint clamp32(longint v, inout bit s);
         if (v > 64'sd2147483647) begin
            s = 1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            s = 1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function longint coef(int r, int c);
         logic [63:0] word;
         logic signed [31:0] half;
         word = matrix[r * 2 + c / 2];
         half = (c % 2) ? word[63:32] : word[31:0];
         return longint'(half);
      endfunction

      function longint divide(longint num, longint den, inout bit s);
         if (den == 0) begin
            s = 1;
            if (num > 0) return 64'sd2147483647;
            if (num < 0) return -64'sd2147483648;
            return 0;
         end
         return clamp32((num <<< FRAC) / den, s);
      endfunction

      function rsp_type transform(req_type b);
         longint lo[3], hi[3], v[4], pt[8][4], mn[3], mx[3], acc;
         bit sat, proj;
         rsp_type o;
         sat = 0;
         lo[0] = b.box_min_x; lo[1] = b.box_min_y; lo[2] = b.box_min_z;
         hi[0] = b.box_max_x; hi[1] = b.box_max_y; hi[2] = b.box_max_z;
         for (int i = 0; i < 8; i++) begin
            v[0] = i[2] ? hi[0] : lo[0];
            v[1] = i[1] ? hi[1] : lo[1];
            v[2] = i[0] ? hi[2] : lo[2];
            v[3] = 64'sd1 <<< FRAC;
            for (int r = 0; r < 4; r++) begin
               acc = 0;
               // arithmetic shift rounds toward minus infinity
               for (int c = 0; c < 4; c++) acc += (coef(r, c) * v[c]) >>> FRAC;
               pt[i][r] = clamp32(acc, sat);
            end
         end
         proj = pt[0][3] != (64'sd1 <<< FRAC) && pt[0][3] > 0;
         if (proj)
            for (int i = 0; i < 8; i++)
               for (int a = 0; a < 3; a++) pt[i][a] = divide(pt[i][a], pt[i][3], sat);
         for (int a = 0; a < 3; a++) begin
            mn[a] = pt[0][a];
            mx[a] = pt[0][a];
            for (int i = 1; i < 8; i++) begin
               if (pt[i][a] < mn[a]) mn[a] = pt[i][a];
               if (pt[i][a] > mx[a]) mx[a] = pt[i][a];
            end
         end
         o.out_min_x = mn[0][31:0]; o.out_min_y = mn[1][31:0]; o.out_min_z = mn[2][31:0];
         o.out_max_x = mx[0][31:0]; o.out_max_y = mx[1][31:0]; o.out_max_z = mx[2][31:0];
         o.projected = proj;
         o.saturated = sat;
         return o;
      endfunction

      function void note_request(req_type b);
         pending_boxes.push_back(transform(b));
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         bit bad;
         if (pending_boxes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected response %h", got);
            return;
         end
         exp = pending_boxes.pop_front();
         bad = got.out_min_x !== exp.out_min_x || got.out_min_y !== exp.out_min_y ||
               got.out_min_z !== exp.out_min_z || got.out_max_x !== exp.out_max_x ||
               got.out_max_y !== exp.out_max_y || got.out_max_z !== exp.out_max_z ||
               got.projected !== exp.projected || got.saturated !== exp.saturated;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: box mismatch at %0t", $realtime);
               $display("  exp min %h %h %h max %h %h %h proj %b sat %b",
                        exp.out_min_x, exp.out_min_y, exp.out_min_z, exp.out_max_x,
                        exp.out_max_y, exp.out_max_z, exp.projected, exp.saturated);
               $display("  got min %h %h %h max %h %h %h proj %b sat %b",
                        got.out_min_x, got.out_min_y, got.out_min_z, got.out_max_x,
                        got.out_max_y, got.out_max_z, got.projected, got.saturated);
            end
         end
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   rsp_type              rsp_data;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_data = '0;

   box_scoreboard sb = new();
   int  idle_cycles = 0;
   int  responses = 0;
   bit  sender_quiet = 0;

   always #5 clock = ~clock;

   aabb_matrix_transform #(.FRAC_BITS(FRAC)) u_dut (.*);

   function automatic int random_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side: random stalls, quiet stretches, and one long hold after
   // the first hundred responses so the pipeline backs up into the request side.
   int hold_left = 0;
   bit hold_done = 0;
   int stall_left = 0;
   int quiet_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (!hold_done && responses >= 100) begin
         hold_done <= 1;
         hold_left <= 400;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if (quiet_left > 0) begin
         quiet_left <= quiet_left - 1;
         rsp_stall <= 0;
      end else if ($urandom_range(0, 99) < 5) begin
         quiet_left <= $urandom_range(20, 200);
         rsp_stall <= 0;
      end else begin
         stall_left <= random_gap(0);
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
         responses <= responses + 1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_box(req_type b);
      int gap;
      gap = random_gap(sender_quiet);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= b;
      do @(posedge clock); while (req_stall);
      sb.note_request(b);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (sb.pending_boxes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_matrix(matrix_reg_type idx, logic [63:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.matrix[idx] = value;
   endtask

   task automatic load_matrix(logic [63:0] m[NUM_REGS]);
      matrix_reg_type idx;
      idx = idx.first();
      for (int i = 0; i < NUM_REGS; i++) begin
         write_matrix(idx, m[i]);
         idx = idx.next();
      end
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pack_elem(int mode);
      case (mode)
         0: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
         1: return $urandom();
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 32'h10_0000) - 32'h8_0000;
      if (r < 90) return $urandom();
      case ($urandom_range(0, 3))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic req_type make_box(logic signed [31:0] a, logic signed [31:0] b,
                                        logic signed [31:0] c, logic signed [31:0] d,
                                        logic signed [31:0] e, logic signed [31:0] f);
      req_type r;
      r.box_min_x = a; r.box_min_y = b; r.box_min_z = c;
      r.box_max_x = d; r.box_max_y = e; r.box_max_z = f;
      return r;
   endfunction

   function automatic req_type rand_box();
      return make_box(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
   endfunction

   task automatic directed_boxes();
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_box(make_box(-32'sh1_0000, -32'sh2_0000, 32'sh1_0000,
                        32'sh3_0000, 32'sh2_0000, 32'sh4_0000));
      // inverted box: min above max
      send_box(make_box(32'sh5_0000, 32'sh5_0000, 32'sh5_0000, -32'sh5_0000, 0, -1));
      send_box(make_box(-1, -1, -1, -1, -1, -1));
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 150 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
         send_box(rand_box());
      end
      sender_quiet = 0;
   endtask

   initial begin
      logic [63:0] m[NUM_REGS];
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // identity from reset
      directed_boxes();
      wait_idle();

      // perspective: w = z + 2.0, zero and negative w on some corners
      foreach (m[i]) m[i] = '0;
      m[ROW0_LO] = 64'h1_0000;
      m[ROW1_LO] = 64'h1_0000 << 32;
      m[ROW2_HI] = 64'h1_0000;
      m[ROW3_HI] = {32'h2_0000, 32'h1_0000};
      load_matrix(m);
      directed_boxes();
      send_box(make_box(32'sh1_0000, 32'sh1_0000, 0, 32'sh3_0000, 32'sh2_0000,
                        -32'sh2_0000));
      send_box(make_box(-32'sh1_0000, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000,
                        -32'sh4_0000));
      send_box(make_box(0, 0, -32'sh1_0000, 0, 0, 32'sh7FFF_FFFF));
      send_box(make_box(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh1_8000, 0, 0, 0));
      wait_idle();

      // all ones, all zeros, largest magnitudes
      foreach (m[i]) m[i] = '1;
      load_matrix(m);
      directed_boxes();
      wait_idle();
      foreach (m[i]) m[i] = '0;
      load_matrix(m);
      directed_boxes();
      wait_idle();
      foreach (m[i]) m[i] = {32'h7FFF_FFFF, 32'h8000_0000};
      load_matrix(m);
      directed_boxes();
      wait_idle();

      // random matrices; half of them perspective-shaped
      for (int p = 0; p < 10; p++) begin
         for (int i = 0; i < NUM_REGS; i++)
            m[i] = {pack_elem($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2)),
                    pack_elem($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2))};
         if (p % 2 == 0)
            m[ROW3_HI] = {32'($urandom_range(32'h1_0000, 32'h8_0000)),
                          32'($urandom_range(0, 32'h2_0000) - 32'h1_0000)};
         load_matrix(m);
         random_phase(100);
         // sender pauses until every outstanding box has come back
         req_valid <= 0;
         while (sb.pending_boxes.size() != 0) @(posedge clock);
         random_phase(100);
         wait_idle();
      end

      if (sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
